// File: sv/fbpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, operation and register codes, controller types and the
// register clamping helpers shared by the allocator files.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int NODE_BYTES_W   = 13;
   localparam int BLOCK_SIZE_W   = 11;
   localparam int MODE_W         = 2;
   localparam int SLOT_FIELD_W   = 10;
   localparam int OFFSET_W       = 22;
   localparam int CSR_INDEX_W    = 4;
   localparam int CSR_DATA_W     = 16;

   localparam int DEF_POOL_SLOTS = 1024;

   localparam logic [NODE_BYTES_W-1:0] DEF_NODE_BYTES = 13'd8;
   localparam logic [NODE_BYTES_W-1:0] MIN_NODE_BYTES = 13'd8;
   localparam logic [NODE_BYTES_W-1:0] MAX_NODE_BYTES = 13'd4096;
   localparam logic [BLOCK_SIZE_W-1:0] DEF_BLOCK_SIZE = 11'd16;
   localparam logic [BLOCK_SIZE_W-1:0] MIN_BLOCK_SIZE = 11'd1;
   localparam logic [BLOCK_SIZE_W-1:0] MAX_BLOCK_SIZE = 11'd1024;

   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_ALLOC    = 2'd0;
   localparam mode_type MODE_FREE     = 2'd1;
   localparam mode_type MODE_FREE_ALL = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_NODE_BYTES = 4'd0;
   localparam csr_index_type CSR_BLOCK_SIZE = 4'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CARVE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take;
      logic pop;
      logic push;
      logic clear;
      logic fail;
      logic nop;
      logic carve_start;
      logic carve_step;
      logic carve_finish;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic op_alloc;
      logic op_push;
      logic op_clear;
      logic head_valid;
      logic exhausted;
      logic rsp_free;
      logic carve_last;
   } status_type;

   function automatic logic [NODE_BYTES_W-1:0] clamp_node_bytes(
      input logic [NODE_BYTES_W-1:0] value
   );
      logic [NODE_BYTES_W-1:0] result;
      result = value;
      if (value < MIN_NODE_BYTES) begin
         result = MIN_NODE_BYTES;
      end else if (value > MAX_NODE_BYTES) begin
         result = MAX_NODE_BYTES;
      end
      return result;
   endfunction

   function automatic logic [BLOCK_SIZE_W-1:0] clamp_block_size(
      input logic [BLOCK_SIZE_W-1:0] value
   );
      logic [BLOCK_SIZE_W-1:0] result;
      result = value;
      if (value < MIN_BLOCK_SIZE) begin
         result = MIN_BLOCK_SIZE;
      end else if (value > MAX_BLOCK_SIZE) begin
         result = MAX_BLOCK_SIZE;
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// File: sv/fbpa_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one alloc, free or free-all operation.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic                    has_slot;
   logic [SLOT_FIELD_W-1:0] slot;

   modport source (output valid, output mode, output has_slot, output slot, input ready);
   modport sink   (input valid, input mode, input has_slot, input slot, output ready);
endinterface
`default_nettype wire

// File: sv/fbpa_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying the status, slot and byte offset of one result.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic [SLOT_FIELD_W-1:0] given_slot;
   logic [OFFSET_W-1:0]     byte_offset;

   modport source (output valid, output ok, output given_slot, output byte_offset,
                   input ready);
   modport sink   (input valid, input ok, input given_slot, input byte_offset,
                   output ready);
endinterface
`default_nettype wire

// File: sv/fbpa_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fbpa_csr_if;
   import fbpa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/fixed_block_pool_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Slot pool with a last-in first-out free list kept in a link memory. Empty
// lists are refilled by carving the next group of slots from the pool.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transfer payload
//  req_ch   in         mode, has_slot, slot
//  rsp_ch   out        ok, given_slot, byte_offset
//  csr_ch   in         index, data (0 node_bytes, 1 block_size)
//
// An alloc from a non-empty list, a free or a free all reads the link memory
// on acceptance and updates the head in the execute state once the response
// register has room. An alloc from an empty list first carves a group; the
// walk writes one link memory entry per cycle, then the finish state sets the
// head. Reset clears the list and carve count and restores register defaults;
// no clearing pass. A full response register stalls execution and new requests.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
   parameter int POOL_SLOTS = fbpa_pkg::DEF_POOL_SLOTS
) (
   input  wire          clock,
   input  wire          reset,
   fbpa_req_if.sink     req_ch,
   fbpa_rsp_if.source   rsp_ch,
   fbpa_csr_if.sink     csr_ch
);
   import fbpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   fbpa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   fbpa_datapath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch),
      .cmd    (cmd),
      .status (status)
   );

   a_one_op_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an operation is in flight");

   a_single_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pop, cmd.push, cmd.clear, cmd.fail, cmd.nop, cmd.carve_finish}))
      else $error("more than one list update in a cycle");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.push || cmd.clear || cmd.fail || cmd.nop || cmd.carve_finish)
      |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response register overwritten");

   a_carve_from_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.carve_start |-> (!status.head_valid && !status.exhausted))
      else $error("carving started with a non-empty list or an exhausted pool");

endmodule
`default_nettype wire

// File: sv/fbpa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// State machine that sequences acceptance, execution, group carving and
// response loading of the allocator datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire fbpa_pkg::status_type status,
   output fbpa_pkg::cmd_type         cmd
);
   import fbpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op_alloc && !status.head_valid && !status.exhausted) begin
               state_in = ST_CARVE;
            end else if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CARVE: begin
            if (status.carve_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
         end
         ST_EXEC: begin
            if (status.op_alloc) begin
               if (status.head_valid) begin
                  cmd.pop = status.rsp_free;
               end else if (status.exhausted) begin
                  cmd.fail = status.rsp_free;
               end else begin
                  cmd.carve_start = 1'b1;
               end
            end else if (status.op_push) begin
               cmd.push = status.rsp_free;
            end else if (status.op_clear) begin
               cmd.clear = status.rsp_free;
            end else begin
               cmd.nop = status.rsp_free;
            end
         end
         ST_CARVE: begin
            cmd.carve_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.carve_finish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: sv/fbpa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator datapath
// Registers, free-list head, link memory, carving pointer, offset multiplier
// and response register of the allocator.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
   parameter int POOL_SLOTS = fbpa_pkg::DEF_POOL_SLOTS
) (
   input  wire                    clock,
   input  wire                    reset,
   fbpa_req_if.sink               req_ch,
   fbpa_rsp_if.source             rsp_ch,
   fbpa_csr_if.sink               csr_ch,
   input  wire fbpa_pkg::cmd_type cmd,
   output fbpa_pkg::status_type   status
);
   import fbpa_pkg::*;

   localparam int SLOT_W  = $clog2(POOL_SLOTS);
   localparam int CNT_W   = $clog2(POOL_SLOTS + 1);
   localparam int LINK_W  = SLOT_W + 1;
   localparam int CMP_W   = ((CNT_W > BLOCK_SIZE_W) ? CNT_W : BLOCK_SIZE_W) + 1;
   localparam int RNG_W   = ((CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W) + 1;
   localparam int PROD_W  = SLOT_W + NODE_BYTES_W;

   logic [NODE_BYTES_W-1:0] node_bytes_ff;
   logic [BLOCK_SIZE_W-1:0] block_size_ff;

   logic [MODE_W-1:0]       mode_ff;
   logic                    has_slot_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;

   logic                    head_valid_ff;
   logic [SLOT_W-1:0]       head_ff;
   logic [CNT_W-1:0]        carved_ff;
   logic [SLOT_W-1:0]       carve_ptr_ff;
   logic [SLOT_W-1:0]       top_ff;
   logic [LINK_W-1:0]       rd_ff;

   logic [LINK_W-1:0]       link_mem [POOL_SLOTS];

   logic                    rsp_valid_ff;
   logic                    rsp_ok_ff;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [OFFSET_W-1:0]     rsp_offset_ff;

   logic                    accept;
   logic                    slot_in_range;
   logic [SLOT_W-1:0]       carved_low;
   logic [SLOT_W-1:0]       top_in;
   logic [SLOT_W-1:0]       mul_slot;
   logic [PROD_W-1:0]       product;
   logic                    rsp_load;
   logic                    rsp_good;

   assign accept        = cmd.take && req_ch.valid;
   assign req_ch.ready  = cmd.take;
   assign csr_ch.ready  = 1'b1;

   assign slot_in_range = RNG_W'(slot_ff) < RNG_W'(POOL_SLOTS);
   assign carved_low    = SLOT_W'(carved_ff);
   assign top_in        = SLOT_W'(CMP_W'(carved_ff) + CMP_W'(block_size_ff) - CMP_W'(1));
   assign mul_slot      = cmd.carve_finish ? top_ff : head_ff;
   assign product       = PROD_W'(mul_slot) * PROD_W'(node_bytes_ff);
   assign rsp_load      = cmd.pop || cmd.push || cmd.clear || cmd.fail || cmd.nop
                          || cmd.carve_finish;
   assign rsp_good      = cmd.pop || cmd.carve_finish;

   always_comb begin
      status            = '0;
      status.req_valid  = req_ch.valid;
      status.op_alloc   = mode_ff == MODE_ALLOC;
      status.op_push    = (mode_ff == MODE_FREE) && has_slot_ff && slot_in_range;
      status.op_clear   = mode_ff == MODE_FREE_ALL;
      status.head_valid = head_valid_ff;
      status.exhausted  = (CMP_W'(POOL_SLOTS) - CMP_W'(carved_ff)) < CMP_W'(block_size_ff);
      status.rsp_free   = !rsp_valid_ff || rsp_ch.ready;
      status.carve_last = carve_ptr_ff == top_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_bytes_ff <= DEF_NODE_BYTES;
         block_size_ff <= DEF_BLOCK_SIZE;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_NODE_BYTES: node_bytes_ff <= clamp_node_bytes(csr_ch.data[NODE_BYTES_W-1:0]);
            CSR_BLOCK_SIZE: block_size_ff <= clamp_block_size(csr_ch.data[BLOCK_SIZE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= req_ch.mode;
         has_slot_ff <= req_ch.has_slot;
         slot_ff     <= req_ch.slot;
         rd_ff       <= link_mem[head_ff];
      end
      if (cmd.carve_start) begin
         carve_ptr_ff <= carved_low;
         top_ff       <= top_in;
      end else if (cmd.carve_step) begin
         carve_ptr_ff <= carve_ptr_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         link_mem[SLOT_W'(slot_ff)] <= {head_valid_ff, head_ff};
      end else if (cmd.carve_step) begin
         link_mem[carve_ptr_ff] <= {carve_ptr_ff != carved_low, carve_ptr_ff - SLOT_W'(1)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         carved_ff     <= '0;
      end else if (cmd.pop) begin
         head_valid_ff <= rd_ff[LINK_W-1];
      end else if (cmd.push) begin
         head_valid_ff <= 1'b1;
      end else if (cmd.clear) begin
         head_valid_ff <= 1'b0;
         carved_ff     <= '0;
      end else if (cmd.carve_finish) begin
         head_valid_ff <= top_ff != carved_low;
         carved_ff     <= CNT_W'(CMP_W'(carved_ff) + CMP_W'(block_size_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         head_ff <= rd_ff[SLOT_W-1:0];
      end else if (cmd.push) begin
         head_ff <= SLOT_W'(slot_ff);
      end else if (cmd.carve_finish) begin
         head_ff <= top_ff - SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ok_ff     <= !cmd.fail;
         rsp_slot_ff   <= rsp_good ? SLOT_FIELD_W'(mul_slot) : '0;
         rsp_offset_ff <= rsp_good ? OFFSET_W'(product) : '0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.given_slot  = rsp_slot_ff;
   assign rsp_ch.byte_offset = rsp_offset_ff;

endmodule
`default_nettype wire

// File: verif/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives alloc, free and free-all requests through the request channel while
// a local model of the free list, the carve count and the registers predicts
// every response. Directed tests cover list order, null and unchecked frees,
// register clamping and pool exhaustion. Random traffic follows under several
// idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
   import fbpa_pkg::*;

   localparam int POOL_SLOTS  = DEF_POOL_SLOTS;
   localparam int CYCLE_LIMIT = 2000000;
   localparam mode_type MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic                    ok;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [OFFSET_W-1:0]     offset;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fbpa_req_if req_ch();
   fbpa_rsp_if rsp_ch();
   fbpa_csr_if csr_ch();

   fixed_block_pool_allocator #(.POOL_SLOTS(POOL_SLOTS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [NODE_BYTES_W-1:0] node_bytes_reg;
   logic [BLOCK_SIZE_W-1:0] block_size_reg;
   logic                    head_valid;
   int unsigned             head_slot;
   logic                    link_valid [POOL_SLOTS];
   int unsigned             link_slot [POOL_SLOTS];
   int unsigned             carved_count;

   alloc_result_type pending_results[$];
   int unsigned      held_slots[$];
   int               error_count = 0;
   int unsigned      cycle_count = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void push_free_slot(int unsigned s);
      link_valid[s] = head_valid;
      link_slot[s]  = head_slot;
      head_valid    = 1'b1;
      head_slot     = s;
   endfunction

   function automatic alloc_result_type predict_pool_op(mode_type mode, logic has_slot,
                                                        logic [SLOT_FIELD_W-1:0] slot);
      alloc_result_type res;
      int unsigned      group;
      int unsigned      bytes;
      int unsigned      h;
      res   = '{ok: 1'b1, slot: '0, offset: '0};
      group = (block_size_reg < MIN_BLOCK_SIZE) ? 32'(MIN_BLOCK_SIZE) :
              (block_size_reg > MAX_BLOCK_SIZE) ? 32'(MAX_BLOCK_SIZE) : 32'(block_size_reg);
      bytes = (node_bytes_reg < MIN_NODE_BYTES) ? 32'(MIN_NODE_BYTES) :
              (node_bytes_reg > MAX_NODE_BYTES) ? 32'(MAX_NODE_BYTES) : 32'(node_bytes_reg);
      case (mode)
         MODE_ALLOC: begin
            if (!head_valid) begin
               if (POOL_SLOTS - carved_count < group) begin
                  res.ok = 1'b0;
               end else begin
                  for (int unsigned i = 0; i < group; i++) begin
                     push_free_slot(carved_count + i);
                  end
                  carved_count += group;
               end
            end
            if (res.ok) begin
               h          = head_slot;
               res.slot   = h[SLOT_FIELD_W-1:0];
               res.offset = OFFSET_W'(h * bytes);
               held_slots.push_back(h);
               head_valid = link_valid[h];
               head_slot  = head_valid ? link_slot[h] : 0;
            end
         end
         MODE_FREE: begin
            if (has_slot && slot < POOL_SLOTS) begin
               push_free_slot(32'(slot));
            end
         end
         MODE_FREE_ALL: begin
            head_valid   = 1'b0;
            head_slot    = 0;
            carved_count = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic send_op(mode_type mode, logic has_slot, logic [SLOT_FIELD_W-1:0] slot);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.has_slot <= has_slot;
      req_ch.slot     <= slot;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(predict_pool_op(mode, has_slot, slot));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (index == CSR_NODE_BYTES) begin
         node_bytes_reg = data[NODE_BYTES_W-1:0];
      end else if (index == CSR_BLOCK_SIZE) begin
         block_size_reg = data[BLOCK_SIZE_W-1:0];
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected transfer: ok %0b given_slot %0d byte_offset %0d",
                      rsp_ch.ok, rsp_ch.given_slot, rsp_ch.byte_offset);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.ok !== want.ok) begin
                  $error("ok: expected %0b, got %0b", want.ok, rsp_ch.ok);
                  error_count++;
               end
               if (rsp_ch.given_slot !== want.slot) begin
                  $error("given_slot: expected %0d, got %0d", want.slot, rsp_ch.given_slot);
                  error_count++;
               end
               if (rsp_ch.byte_offset !== want.offset) begin
                  $error("byte_offset: expected %0d, got %0d", want.offset,
                         rsp_ch.byte_offset);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= int'($urandom_range(0, 99)) >= rsp_stall_pct;
      end
   end

   // Default settings: groups of sixteen, eight bytes per slot.
   task automatic test_list_order();
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_ALLOC, 1'b1, 10'h3FF);
      send_op(MODE_FREE, 1'b1, 10'd14);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_FREE, 1'b0, 10'h3FF);
      send_op(MODE_UNUSED, 1'b1, 10'h3FF);
      send_op(MODE_FREE, 1'b1, 10'd1023);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_FREE, 1'b1, 10'd13);
      send_op(MODE_FREE, 1'b1, 10'd13);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_FREE_ALL, 1'b0, 10'd0);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
   endtask

   task automatic test_node_bytes_clamp();
      write_csr(CSR_NODE_BYTES, 16'd7);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      write_csr(CSR_NODE_BYTES, 16'd4097);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      write_csr(CSR_NODE_BYTES, 16'd8191);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
   endtask

   task automatic test_pool_exhaustion();
      write_csr(CSR_NODE_BYTES, 16'd4096);
      send_op(MODE_FREE_ALL, 1'b1, 10'h3FF);
      write_csr(CSR_BLOCK_SIZE, 16'd0);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      write_csr(CSR_BLOCK_SIZE, 16'd2047);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_FREE, 1'b1, 10'd5);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      write_csr(CSR_BLOCK_SIZE, 16'd1023);
      send_op(MODE_ALLOC, 1'b0, 10'd0);
      send_op(MODE_FREE_ALL, 1'b0, 10'd0);
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct);
      int unsigned             pick;
      int unsigned             k;
      logic [CSR_DATA_W-1:0]   value;
      logic [SLOT_FIELD_W-1:0] slot;
      wait_idle();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int seg = 0; seg < 4; seg++) begin
         case ($urandom_range(0, 15))
            0:       value = 16'd0;
            1:       value = 16'd7;
            2:       value = 16'd8;
            3:       value = 16'd4096;
            4:       value = 16'd4097;
            5:       value = 16'd8191;
            default: value = CSR_DATA_W'($urandom_range(8, 4096));
         endcase
         write_csr(CSR_NODE_BYTES, value);
         case ($urandom_range(0, 19))
            0:       value = 16'd0;
            1:       value = 16'd1024;
            2:       value = 16'd1025;
            3:       value = 16'd2047;
            4:       value = CSR_DATA_W'($urandom_range(65, 1023));
            5, 6:    value = CSR_DATA_W'($urandom_range(17, 64));
            default: value = CSR_DATA_W'($urandom_range(1, 16));
         endcase
         write_csr(CSR_BLOCK_SIZE, value);
         for (int n = 0; n < 25; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               send_op(MODE_ALLOC, 1'($urandom), 10'($urandom));
            end else if (pick < 80 && held_slots.size() != 0) begin
               k    = $urandom_range(0, held_slots.size() - 1);
               slot = SLOT_FIELD_W'(held_slots[k]);
               held_slots.delete(k);
               send_op(MODE_FREE, 1'b1, slot);
            end else if (pick < 88) begin
               send_op(MODE_FREE, 1'b1, 10'($urandom));
            end else if (pick < 93) begin
               send_op(MODE_FREE, 1'b0, 10'($urandom));
            end else if (pick < 97) begin
               send_op(MODE_UNUSED, 1'($urandom), 10'($urandom));
            end else begin
               held_slots.delete();
               send_op(MODE_FREE_ALL, 1'($urandom), 10'($urandom));
            end
         end
      end
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.mode     = MODE_ALLOC;
      req_ch.has_slot = 1'b0;
      req_ch.slot     = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_NODE_BYTES;
      csr_ch.data     = '0;
      node_bytes_reg  = DEF_NODE_BYTES;
      block_size_reg  = DEF_BLOCK_SIZE;
      head_valid      = 1'b0;
      head_slot       = 0;
      carved_count    = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_list_order();
      test_node_bytes_clamp();
      test_pool_exhaustion();
      test_random_traffic(0, 0);
      test_random_traffic(67, 0);
      test_random_traffic(0, 67);
      test_random_traffic(20, 20);

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/fbpa_pkg.sv
sv/fbpa_req_if.sv
sv/fbpa_rsp_if.sv
sv/fbpa_csr_if.sv
sv/fbpa_ctrl.sv
sv/fbpa_datapath.sv
sv/fixed_block_pool_allocator.sv
verif/tb_fixed_block_pool_allocator.sv
